// ===== rtl/uvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_SEGMENTS = 2'd1,
    REG_RINGS    = 2'd2
  } cfg_reg_e;

  // Phase is in units of 2^-20 turn
  localparam int PHASE_W = 20;

  // Restoring divider: one quotient bit per stage
  localparam int DIV_ST = 21;

  // Sin/cos pipeline: two set-up stages, three per Taylor term, one final
  localparam int N_TERMS = 6;
  localparam int SC_LAT  = 2 + 3 * N_TERMS + 1;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // Term divisors; the last sine entry is never accumulated
  localparam logic [7:0] SIN_DIV [N_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd2};
  localparam logic [7:0] COS_DIV [N_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};

  // floor(2^32 / divisor)
  localparam logic [31:0] SIN_RCP [N_TERMS] = '{
    32'(64'd4294967296 / 64'd6),  32'(64'd4294967296 / 64'd20),
    32'(64'd4294967296 / 64'd42), 32'(64'd4294967296 / 64'd72),
    32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd2)
  };
  localparam logic [31:0] COS_RCP [N_TERMS] = '{
    32'(64'd4294967296 / 64'd2),  32'(64'd4294967296 / 64'd12),
    32'(64'd4294967296 / 64'd30), 32'(64'd4294967296 / 64'd56),
    32'(64'd4294967296 / 64'd90), 32'(64'd4294967296 / 64'd132)
  };

  // Sine and cosine, signed Q30
  typedef struct packed {
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
  } sc_t;

  // Per-item data that rides alongside the trig pipeline
  typedef struct packed {
    logic        quad_valid;
    logic [16:0] quad_index;
    logic [16:0] quad_next_index;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

endpackage

// ===== rtl/uv_sphere_vertex_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit
// Turns a (column, row) grid point into a UV sphere vertex: position,
// normal, texture coordinates and quad indices.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: col[8:0], row[17:9]
//  m_axis    out        tdata: pos xyz, normal xyz, tex uv, quad flag/indices
//  cfg       in         write: 0 radius, 1 segment count, 2 ring count
//
//  One item per cycle; stages: input register, 21-stage restoring
//  dividers (one quotient bit a stage), 21-stage sin/cos pipeline, 4 stages
//  of normal and position products. Reset clears all valid bits and loads
//  the register defaults. When a result is held unread the whole pipeline
//  freezes; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_unit #(
  parameter int MAX_SEGMENTS = 256,
  parameter int MAX_RINGS    = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // col, row
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y,
                                       // norm_z, tex_u, tex_v, quad_valid,
                                       // quad_index, quad_next_index
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int DST   = uvs_pkg::DIV_ST;
  localparam int SCL   = uvs_pkg::SC_LAT;
  localparam int TOTAL = 1 + DST + SCL + 4;

  // Configuration registers
  logic [15:0] radius_q;
  logic [8:0]  segment_count_q, ring_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q        <= 16'd256;
      segment_count_q <= 9'd32;
      ring_count_q    <= 9'd16;
    end else if (cfg_we_i) begin
      unique case (uvs_pkg::cfg_reg_e'(cfg_idx_i))
        uvs_pkg::REG_RADIUS:   radius_q        <= cfg_wdata_i;
        uvs_pkg::REG_SEGMENTS: segment_count_q <= cfg_wdata_i[8:0];
        uvs_pkg::REG_RINGS:    ring_count_q    <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero acts as one, capped at the maximum
  logic [8:0] seg_w, ring_w;

  always_comb begin
    if (segment_count_q == '0) begin
      seg_w = 9'd1;
    end else if ({2'b0, segment_count_q} > 11'(MAX_SEGMENTS)) begin
      seg_w = 9'(MAX_SEGMENTS);
    end else begin
      seg_w = segment_count_q;
    end
    if (ring_count_q == '0) begin
      ring_w = 9'd1;
    end else if ({2'b0, ring_count_q} > 11'(MAX_RINGS)) begin
      ring_w = 9'(MAX_RINGS);
    end else begin
      ring_w = ring_count_q;
    end
  end

  // Global advance: stop only when the output holds an unread item
  logic             en;
  logic [TOTAL-1:0] vld_q;

  assign en            = !vld_q[TOTAL-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[TOTAL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL-2:0], s_axis_tvalid};
    end
  end

  // Input register with clamped grid point
  logic [8:0] col_c, row_c, col_q, row_q;

  assign col_c = (s_axis_tdata[8:0]  > seg_w)  ? seg_w  : s_axis_tdata[8:0];
  assign row_c = (s_axis_tdata[17:9] > ring_w) ? ring_w : s_axis_tdata[17:9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q <= col_c;
      row_q <= row_c;
    end
  end

  // Quad flag and indices
  logic [9:0]     seg_p1;
  logic [18:0]    qi_full, qni_full;
  uvs_pkg::side_t side_c;

  always_comb begin
    seg_p1   = 10'(seg_w) + 10'd1;
    qi_full  = 19'(row_q) * 19'(seg_p1) + 19'(col_q);
    qni_full = qi_full + 19'(seg_p1);
    side_c.quad_valid      = (col_q < seg_w) && (row_q < ring_w);
    side_c.quad_index      = qi_full[16:0];
    side_c.quad_next_index = qni_full[16:0];
    side_c.tex_u           = '0;
    side_c.tex_v           = '0;
  end

  // Divider lanes: longitude phase, latitude phase, tex u, tex v
  logic [29:0] num_w [4];
  logic [8:0]  den_w [4];

  always_comb begin
    num_w[0] = (30'(col_q) << 20) + 30'(seg_w >> 1);
    num_w[1] = (30'(row_q) << 19) + 30'(ring_w >> 1);
    num_w[2] = (30'(col_q) << 16) + 30'(seg_w >> 1);
    num_w[3] = (30'(row_q) << 16) + 30'(ring_w >> 1);
    den_w[0] = seg_w;
    den_w[1] = ring_w;
    den_w[2] = seg_w;
    den_w[3] = ring_w;
  end

  logic [8:0]  rem_q [4][DST];
  logic [20:0] nb_q  [4][DST];
  logic [20:0] quo_q [4][DST];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    for (genvar i = 0; i < DST; i++) begin : g_stage
      logic [8:0]  r_src;
      logic [20:0] n_src, q_src;
      logic [9:0]  trial;
      logic        ge;

      if (i == 0) begin : g_init
        assign r_src = num_w[l][29:21];
        assign n_src = num_w[l][20:0];
        assign q_src = '0;
      end else begin : g_chain
        assign r_src = rem_q[l][i-1];
        assign n_src = nb_q[l][i-1];
        assign q_src = quo_q[l][i-1];
      end

      assign trial = {r_src, n_src[20]};
      assign ge    = trial >= {1'b0, den_w[l]};

      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[l][i] <= ge ? 9'(trial - {1'b0, den_w[l]}) : trial[8:0];
          nb_q[l][i]  <= {n_src[19:0], 1'b0};
          quo_q[l][i] <= {q_src[19:0], ge};
        end
      end
    end
  end

  // Side data along the dividers
  uvs_pkg::side_t sdiv_q [DST];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdiv_q[0] <= side_c;
      for (int i = 1; i < DST; i++) begin
        sdiv_q[i] <= sdiv_q[i-1];
      end
    end
  end

  // Trig units
  uvs_pkg::sc_t lon_sc, lat_sc;

  uvs_sincos u_lon (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (quo_q[0][DST-1][19:0]),
    .res_o   (lon_sc)
  );

  uvs_sincos u_lat (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (quo_q[1][DST-1][19:0]),
    .res_o   (lat_sc)
  );

  // Side data and texture coordinates alongside the trig units
  uvs_pkg::side_t side_tx;
  uvs_pkg::side_t ssc_q [SCL];

  always_comb begin
    side_tx       = sdiv_q[DST-1];
    side_tx.tex_u = quo_q[2][DST-1][16:0];
    side_tx.tex_v = quo_q[3][DST-1][16:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ssc_q[0] <= side_tx;
      for (int i = 1; i < SCL; i++) begin
        ssc_q[i] <= ssc_q[i-1];
      end
    end
  end

  // Post 1: magnitude products of the normal
  logic [30:0]    ma, mb, mc;
  logic [61:0]    px_q, pz_q;
  logic [30:0]    ny1_q;
  logic [2:0]     neg1_q;
  uvs_pkg::side_t side1_q;

  assign ma = 31'(lon_sc.cos_v[31] ? -lon_sc.cos_v : lon_sc.cos_v);
  assign mb = 31'(lat_sc.sin_v[31] ? -lat_sc.sin_v : lat_sc.sin_v);
  assign mc = 31'(lon_sc.sin_v[31] ? -lon_sc.sin_v : lon_sc.sin_v);

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q      <= 62'(ma) * 62'(mb);
      pz_q      <= 62'(mc) * 62'(mb);
      ny1_q     <= 31'(lat_sc.cos_v[31] ? -lat_sc.cos_v : lat_sc.cos_v);
      neg1_q[0] <= lon_sc.cos_v[31] ^ lat_sc.sin_v[31];
      neg1_q[1] <= lat_sc.cos_v[31];
      neg1_q[2] <= lon_sc.sin_v[31] ^ lat_sc.sin_v[31];
      side1_q   <= ssc_q[SCL-1];
    end
  end

  // Post 2: round products to Q30
  logic [30:0]    m2_q [3];
  logic [2:0]     neg2_q;
  uvs_pkg::side_t side2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_q[0] <= 31'((px_q + (62'd1 << 29)) >> 30);
      m2_q[1] <= ny1_q;
      m2_q[2] <= 31'((pz_q + (62'd1 << 29)) >> 30);
      neg2_q  <= neg1_q;
      side2_q <= side1_q;
    end
  end

  // Post 3: position products and Q14 normals
  logic [46:0]    pp_q  [3];
  logic [14:0]    n14_q [3];
  logic [2:0]     neg3_q;
  uvs_pkg::side_t side3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pp_q[j]  <= 47'(m2_q[j]) * 47'(radius_q);
        n14_q[j] <= 15'((32'(m2_q[j]) + 32'h8000) >> 16);
      end
      neg3_q  <= neg2_q;
      side3_q <= side2_q;
    end
  end

  // Post 4: output register
  logic [16:0]    pmag [3];
  logic [16:0]    pos_q  [3];
  logic [15:0]    norm_q [3];
  uvs_pkg::side_t side4_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pmag[j] = 17'((pp_q[j] + (47'd1 << 29)) >> 30);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pos_q[j]  <= neg3_q[j] ? -pmag[j] : pmag[j];
        norm_q[j] <= neg3_q[j] ? -16'(n14_q[j]) : 16'(n14_q[j]);
      end
      side4_q <= side3_q;
    end
  end

  assign m_axis_tdata = {side4_q.quad_next_index, side4_q.quad_index, side4_q.quad_valid,
                         side4_q.tex_v, side4_q.tex_u,
                         norm_q[2], norm_q[1], norm_q[0],
                         pos_q[2], pos_q[1], pos_q[0]};

endmodule

// ===== rtl/uvs_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_sincos
// Pipelined sine/cosine of a 20-bit phase, Taylor series in Q30.
// ----------------------------------------------------------------------------
module uvs_sincos (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [uvs_pkg::PHASE_W-1:0]   phase_i,
  output uvs_pkg::sc_t                  res_o
);

  localparam int NT = uvs_pkg::N_TERMS;

  // Stage 1: quadrant and angle in Q30
  logic [1:0]  q1_q;
  logic [30:0] th_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q <= phase_i[19:18];
      th_q <= 31'((50'(phase_i[17:0]) * 50'(uvs_pkg::PI_Q30)) >> 19);
    end
  end

  // Stage 2: angle squared
  logic [1:0]  q2_q;
  logic [30:0] th2_q;
  logic [31:0] t2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q2_q  <= q1_q;
      th2_q <= th_q;
      t2_q  <= 32'((62'(th_q) * 62'(th_q)) >> 30);
    end
  end

  // Term stages: product, reciprocal estimate, correction and sum
  logic [1:0]         qa_q  [NT];
  logic [31:0]        t2a_q [NT];
  logic signed [33:0] sa_q  [NT];
  logic signed [33:0] ca_q  [NT];
  logic [63:0]        ps_q  [NT];
  logic [63:0]        pc_q  [NT];

  logic [1:0]         qb_q  [NT];
  logic [31:0]        t2b_q [NT];
  logic signed [33:0] sb_q  [NT];
  logic signed [33:0] cb_q  [NT];
  logic [33:0]        xs_q  [NT];
  logic [33:0]        xc_q  [NT];
  logic [33:0]        es_q  [NT];
  logic [33:0]        ec_q  [NT];

  logic [1:0]         qc_q  [NT];
  logic [31:0]        t2c_q [NT];
  logic [31:0]        ts_q  [NT];
  logic [31:0]        tc_q  [NT];
  logic signed [33:0] sc_q  [NT];
  logic signed [33:0] cc_q  [NT];

  for (genvar k = 0; k < NT; k++) begin : g_term
    logic [1:0]         src_q;
    logic [31:0]        src_t2;
    logic [31:0]        src_ts;
    logic [31:0]        src_tc;
    logic signed [33:0] src_s;
    logic signed [33:0] src_c;
    logic [33:0]        rem_s, rem_c, tn_s, tn_c;

    if (k == 0) begin : g_first
      assign src_q  = q2_q;
      assign src_t2 = t2_q;
      assign src_ts = 32'(th2_q);
      assign src_tc = uvs_pkg::ONE_Q30;
      assign src_s  = signed'(34'(th2_q));
      assign src_c  = signed'(34'(uvs_pkg::ONE_Q30));
    end else begin : g_next
      assign src_q  = qc_q[k-1];
      assign src_t2 = t2c_q[k-1];
      assign src_ts = ts_q[k-1];
      assign src_tc = tc_q[k-1];
      assign src_s  = sc_q[k-1];
      assign src_c  = cc_q[k-1];
    end

    // previous term times theta^2
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qa_q[k]  <= src_q;
        t2a_q[k] <= src_t2;
        sa_q[k]  <= src_s;
        ca_q[k]  <= src_c;
        ps_q[k]  <= 64'(src_ts) * 64'(src_t2);
        pc_q[k]  <= 64'(src_tc) * 64'(src_t2);
      end
    end

    // quotient estimate, at most two below the true value
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qb_q[k]  <= qa_q[k];
        t2b_q[k] <= t2a_q[k];
        sb_q[k]  <= sa_q[k];
        cb_q[k]  <= ca_q[k];
        xs_q[k]  <= ps_q[k][63:30];
        xc_q[k]  <= pc_q[k][63:30];
        es_q[k]  <= 34'((66'(ps_q[k][63:30]) * 66'(uvs_pkg::SIN_RCP[k])) >> 32);
        ec_q[k]  <= 34'((66'(pc_q[k][63:30]) * 66'(uvs_pkg::COS_RCP[k])) >> 32);
      end
    end

    // correct the estimate from the remainder
    always_comb begin
      rem_s = xs_q[k] - 34'(es_q[k] * 34'(uvs_pkg::SIN_DIV[k]));
      rem_c = xc_q[k] - 34'(ec_q[k] * 34'(uvs_pkg::COS_DIV[k]));
      if (rem_s >= 34'({uvs_pkg::SIN_DIV[k], 1'b0})) begin
        tn_s = es_q[k] + 34'd2;
      end else if (rem_s >= 34'(uvs_pkg::SIN_DIV[k])) begin
        tn_s = es_q[k] + 34'd1;
      end else begin
        tn_s = es_q[k];
      end
      if (rem_c >= 34'({uvs_pkg::COS_DIV[k], 1'b0})) begin
        tn_c = ec_q[k] + 34'd2;
      end else if (rem_c >= 34'(uvs_pkg::COS_DIV[k])) begin
        tn_c = ec_q[k] + 34'd1;
      end else begin
        tn_c = ec_q[k];
      end
    end

    // series alternates sign, first term subtracted
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qc_q[k]  <= qb_q[k];
        t2c_q[k] <= t2b_q[k];
        ts_q[k]  <= 32'(tn_s);
        tc_q[k]  <= 32'(tn_c);
        if (k >= NT - 1) begin
          sc_q[k] <= sb_q[k];
        end else if ((k % 2) == 0) begin
          sc_q[k] <= sb_q[k] - signed'(tn_s);
        end else begin
          sc_q[k] <= sb_q[k] + signed'(tn_s);
        end
        if ((k % 2) == 0) begin
          cc_q[k] <= cb_q[k] - signed'(tn_c);
        end else begin
          cc_q[k] <= cb_q[k] + signed'(tn_c);
        end
      end
    end
  end

  // Final stage: clamp to [0, 1.0] and map quadrant
  logic signed [31:0] s_cl, c_cl;
  uvs_pkg::sc_t       res_d, res_q;

  always_comb begin
    if (sc_q[NT-1] < 0) begin
      s_cl = '0;
    end else if (sc_q[NT-1] > signed'(34'(uvs_pkg::ONE_Q30))) begin
      s_cl = signed'(uvs_pkg::ONE_Q30);
    end else begin
      s_cl = signed'(32'(sc_q[NT-1]));
    end
    if (cc_q[NT-1] < 0) begin
      c_cl = '0;
    end else if (cc_q[NT-1] > signed'(34'(uvs_pkg::ONE_Q30))) begin
      c_cl = signed'(uvs_pkg::ONE_Q30);
    end else begin
      c_cl = signed'(32'(cc_q[NT-1]));
    end
    unique case (qc_q[NT-1])
      2'd0: begin res_d.sin_v = s_cl;  res_d.cos_v = c_cl;  end
      2'd1: begin res_d.sin_v = c_cl;  res_d.cos_v = -s_cl; end
      2'd2: begin res_d.sin_v = -s_cl; res_d.cos_v = -c_cl; end
      default: begin res_d.sin_v = -c_cl; res_d.cos_v = s_cl; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
